### rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
// Needs signals clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check outside reset
`define Q_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("assertion failed");

// check at every edge, reset included
`define Q_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("assertion failed");

`endif

### rtl/core/q24a_pkg.sv
// Types, constants and operation codes of the Q24.8 fixed-point ALU.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package q24a_pkg;
	localparam int WORD_BITS     = 32;
	localparam int FRACTION_BITS = 8;
	localparam int FIELD_BITS    = 32;
	localparam int NUM_BITS      = WORD_BITS + FRACTION_BITS;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

	typedef enum logic [3:0] {
		OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_GT, OP_LE, OP_GE,
		OP_EQ, OP_NE, OP_INC, OP_DEC, OP_MIN, OP_MAX, OP_INT2FIX, OP_FIX2INT
	} op_t;

	typedef struct packed {
		logic [3:0]                   operation;
		logic signed [FIELD_BITS-1:0] operand_a;
		logic signed [FIELD_BITS-1:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [FIELD_BITS-1:0] result_raw;
		logic                         compare_true;
		logic                         divide_by_zero;
	} rsp_t;

	typedef struct packed {
		op_t                         op;
		logic                        is_div;
		logic signed [WORD_BITS-1:0] a;
		logic signed [WORD_BITS-1:0] b;
	} work_t;
endpackage
`default_nettype wire

### rtl/core/q24a_front.sv
// Front stage: accepts requests, trims operands to the word and tags divides.
// Depends on q24a_pkg.
`timescale 1ns / 1ps
`default_nettype none
module q24a_front import q24a_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	output logic       full,
	input  wire req_t  req,
	output logic       work_valid,
	input  wire logic  work_full,
	output work_t      work
);
	logic  valid_s1;
	work_t work_s1;
	logic  take;

	assign full       = valid_s1 && work_full;
	assign take       = push && !full;
	assign work_valid = valid_s1;
	assign work       = work_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!full) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			work_s1.op     <= op_t'(req.operation);
			work_s1.is_div <= op_t'(req.operation) == OP_DIV;
			work_s1.a      <= req.operand_a[WORD_BITS-1:0];
			work_s1.b      <= req.operand_b[WORD_BITS-1:0];
		end
	end
endmodule
`default_nettype wire

### rtl/core/q24a_fifo.sv
// Short register queue between front and back.
// Depends on q24a_pkg.
`timescale 1ns / 1ps
`default_nettype none
module q24a_fifo import q24a_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr_valid,
	output logic       wr_full,
	input  wire work_t wr_data,
	output logic       rd_empty,
	input  wire logic  rd_pop,
	output work_t      rd_data
);
	work_t                mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;
	logic                 do_wr;
	logic                 do_rd;

	assign wr_full  = count_q == (QPTR_BITS+1)'(QUEUE_DEPTH);
	assign rd_empty = count_q == '0;
	assign do_wr    = wr_valid && !wr_full;
	assign do_rd    = rd_pop && !rd_empty;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end
endmodule
`default_nettype wire

### rtl/core/q24a_back.sv
// Back pipeline: operand prep and multiply, one restoring divide bit per stage,
// then sign fix and the result register. Depends on q24a_pkg.
`timescale 1ns / 1ps
`default_nettype none
module q24a_back import q24a_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  src_empty,
	output logic       src_pop,
	input  wire work_t src,
	output logic       empty,
	input  wire logic  pop,
	output rsp_t       rsp
);
	localparam int LAST = NUM_BITS + 1;

	logic                        v_s   [LAST+1];
	logic signed [WORD_BITS-1:0] res_s [NUM_BITS+1];
	logic                        cmp_s [NUM_BITS+1];
	logic                        dz_s  [NUM_BITS+1];
	logic                        div_s [NUM_BITS+1];
	logic                        neg_s [NUM_BITS+1];
	logic [WORD_BITS:0]          rem_s [NUM_BITS+1];
	logic [NUM_BITS-1:0]         nq_s  [NUM_BITS+1];
	logic [WORD_BITS-1:0]        d_s   [NUM_BITS+1];
	rsp_t                        out_s;

	logic                          en;
	logic signed [2*WORD_BITS-1:0] prod;
	logic signed [NUM_BITS-1:0]    num;
	logic [NUM_BITS-1:0]           num_mag;
	logic [WORD_BITS-1:0]          d_mag;
	logic signed [WORD_BITS-1:0]   res_c;
	logic                          cmp_c;
	logic                          dz_c;
	logic [WORD_BITS:0]            trial [NUM_BITS+1];
	logic                          ge    [NUM_BITS+1];
	logic [WORD_BITS-1:0]          quo;
	logic signed [WORD_BITS-1:0]   res_f;

	assign en      = !v_s[LAST] || pop;
	assign src_pop = en && !src_empty;
	assign empty   = !v_s[LAST];
	assign rsp     = out_s;

	assign prod    = src.a * src.b;
	assign num     = {src.a, {FRACTION_BITS{1'b0}}};
	assign num_mag = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
	assign d_mag   = src.b[WORD_BITS-1] ? WORD_BITS'(-src.b) : WORD_BITS'(src.b);
	assign dz_c    = src.is_div && (src.b == '0);

	always_comb begin
		res_c = '0;
		cmp_c = 1'b0;
		case (src.op)
			OP_ADD:     res_c = src.a + src.b;
			OP_SUB:     res_c = src.a - src.b;
			OP_MUL:     res_c = prod[WORD_BITS+FRACTION_BITS-1:FRACTION_BITS];
			OP_DIV:     res_c = '0;
			OP_LT:      cmp_c = src.a < src.b;
			OP_GT:      cmp_c = src.a > src.b;
			OP_LE:      cmp_c = src.a <= src.b;
			OP_GE:      cmp_c = src.a >= src.b;
			OP_EQ:      cmp_c = src.a == src.b;
			OP_NE:      cmp_c = src.a != src.b;
			OP_INC:     res_c = src.a + WORD_BITS'(1);
			OP_DEC:     res_c = src.a - WORD_BITS'(1);
			OP_MIN:     res_c = (src.a < src.b) ? src.a : src.b;
			OP_MAX:     res_c = (src.a > src.b) ? src.a : src.b;
			OP_INT2FIX: res_c = src.a <<< FRACTION_BITS;
			OP_FIX2INT: res_c = src.a >>> FRACTION_BITS;
			default:    res_c = '0;
		endcase
	end

	always_comb begin
		trial[0] = '0;
		ge[0]    = 1'b0;
		for (int k = 1; k <= NUM_BITS; k++) begin
			trial[k] = {rem_s[k-1][WORD_BITS-1:0], nq_s[k-1][NUM_BITS-1]};
			ge[k]    = trial[k] >= {1'b0, d_s[k-1]};
		end
	end

	assign quo   = nq_s[NUM_BITS][WORD_BITS-1:0];
	assign res_f = (div_s[NUM_BITS] && !dz_s[NUM_BITS])
		? (neg_s[NUM_BITS] ? WORD_BITS'(-quo) : WORD_BITS'(quo))
		: res_s[NUM_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= LAST; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= !src_empty;
			for (int k = 1; k <= LAST; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s[0] <= res_c;
			cmp_s[0] <= cmp_c;
			dz_s[0]  <= dz_c;
			div_s[0] <= src.is_div;
			neg_s[0] <= src.a[WORD_BITS-1] ^ src.b[WORD_BITS-1];
			rem_s[0] <= '0;
			nq_s[0]  <= num_mag;
			d_s[0]   <= d_mag;
			for (int k = 1; k <= NUM_BITS; k++) begin
				res_s[k] <= res_s[k-1];
				cmp_s[k] <= cmp_s[k-1];
				dz_s[k]  <= dz_s[k-1];
				div_s[k] <= div_s[k-1];
				neg_s[k] <= neg_s[k-1];
				d_s[k]   <= d_s[k-1];
				rem_s[k] <= ge[k] ? trial[k] - {1'b0, d_s[k-1]} : trial[k];
				nq_s[k]  <= {nq_s[k-1][NUM_BITS-2:0], ge[k]};
			end
			out_s.result_raw     <= FIELD_BITS'(res_f);
			out_s.compare_true   <= cmp_s[NUM_BITS];
			out_s.divide_by_zero <= dz_s[NUM_BITS];
		end
	end
endmodule
`default_nettype wire

### rtl/core/fixed_point_q24_8_alu_core.sv
// Q24.8 fixed-point ALU. Path from push to result: front register, queue,
// prep/multiply stage, 40 divide-bit stages, result register. Throughput: one item
// per cycle while results are popped; the divide runs one quotient bit per stage.
// A stalled result freezes the back pipeline; the queue lets the front run until full.
// Reset (arst_n, asynchronous, low) empties all stages and the queue.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_q24_8_alu_core import q24a_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic      full,
	input  wire req_t req,
	output logic      empty,
	input  wire logic pop,
	output rsp_t      rsp
);
	logic  f_valid;
	logic  f_full;
	work_t f_work;
	logic  q_empty;
	logic  q_pop;
	work_t q_work;

	q24a_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.work_valid(f_valid), .work_full(f_full), .work(f_work)
	);

	q24a_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_valid(f_valid), .wr_full(f_full),
		.wr_data(f_work), .rd_empty(q_empty), .rd_pop(q_pop), .rd_data(q_work)
	);

	q24a_back u_back (
		.clk(clk), .arst_n(arst_n), .src_empty(q_empty), .src_pop(q_pop),
		.src(q_work), .empty(empty), .pop(pop), .rsp(rsp)
	);
endmodule
`default_nettype wire

### rtl/core/q24a_checker.sv
// Port-level checks of the ALU core, bound to the top level.
// Depends on q24a_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module q24a_checker import q24a_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic empty,
	input wire logic pop,
	input wire rsp_t rsp
);
	`Q_ASSERT_ALWAYS(a_rst_empty, !arst_n |-> empty)
	`Q_ASSERT(a_hold, !empty && !pop |=> !empty)
	`Q_ASSERT(a_stable, !empty && !pop |=> $stable(rsp))
	`Q_ASSERT(a_dz_zero, !empty && rsp.divide_by_zero |-> rsp.result_raw == '0 && !rsp.compare_true)
	`Q_ASSERT(a_cmp_zero, !empty && rsp.compare_true |-> rsp.result_raw == '0)
endmodule

bind fixed_point_q24_8_alu_core q24a_checker u_chk (.*);
`default_nettype wire
